/* rtl/nds_pkg.sv */
package nds_pkg;

   localparam int MaxSteps   = 64;
   localparam int PosW       = $clog2(MaxSteps);
   localparam int CountW     = 7;
   localparam int CsrIndexW  = 3;
   localparam int CsrDataW   = 32;
   localparam int TimeW      = 16;
   localparam int SumW       = TimeW + 2;
   localparam int DividendW  = 2 * TimeW;
   localparam int DivCountW  = $clog2(DividendW);

   typedef enum logic [2:0] {
      CMD_TICK      = 3'd0,
      CMD_TRIGGER   = 3'd1,
      CMD_WR_NOTE   = 3'd2,
      CMD_WR_DUR    = 3'd3,
      CMD_WR_ENV    = 3'd4,
      CMD_RESTART   = 3'd5,
      CMD_RSVD6     = 3'd6,
      CMD_RSVD7     = 3'd7
   } cmd_type;

   typedef enum logic [CsrIndexW-1:0] {
      CSR_SAMPLES_PER_UNIT = 3'd0,
      CSR_MS_PER_UNIT      = 3'd1,
      CSR_NOTE_COUNT       = 3'd2,
      CSR_DURATION_COUNT   = 3'd3,
      CSR_MANUAL_MODE      = 3'd4,
      CSR_ELASTIC_SUSTAIN  = 3'd5,
      CSR_SUSTAIN_LEVEL    = 3'd6,
      CSR_UNUSED           = 3'd7
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_LEN,
      ST_SCALE,
      ST_DIV,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      OP_MANUAL,
      OP_AUTO,
      OP_RESTART
   } op_type;

   typedef struct packed {
      logic start;
   } div_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;

   typedef struct packed {
      logic [PosW-1:0] pos;
      logic            wrap;
   } step_type;

   localparam logic [TimeW-1:0] EnvResetA = 16'd10;
   localparam logic [TimeW-1:0] EnvResetD = 16'd10;
   localparam logic [TimeW-1:0] EnvResetS = 16'd100;
   localparam logic [TimeW-1:0] EnvResetR = 16'd10;

   localparam logic [31:0]       MsPerUnitReset = 32'd3932160;
   localparam logic [CountW-1:0] CountReset     = 7'd3;

   function automatic logic [CountW:0] clamp_count(input logic [CountW-1:0] c);
      logic [CountW:0] r;
      r = {1'b0, c};
      if (c < CountW'(2)) r = (CountW+1)'(2);
      else if ({1'b0, c} > (CountW+1)'(MaxSteps)) r = (CountW+1)'(MaxSteps);
      return r;
   endfunction

   function automatic step_type advance(input logic [PosW-1:0] pos,
                                        input logic [CountW-1:0] c);
      logic [CountW:0] n;
      step_type        s;
      n = (CountW+1)'(pos) + (CountW+1)'(1);
      if (n >= clamp_count(c)) begin
         s.pos  = '0;
         s.wrap = 1'b1;
      end else begin
         s.pos  = n[PosW-1:0];
         s.wrap = 1'b0;
      end
      return s;
   endfunction

   function automatic logic [PosW-1:0] last_pos(input logic [CountW-1:0] c);
      logic [CountW:0] m;
      m = clamp_count(c) - (CountW+1)'(1);
      return m[PosW-1:0];
   endfunction

endpackage

/* rtl/nds_if.sv */
interface nds_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  command;
   logic [5:0]  index;
   logic [31:0] value;
   modport source (output valid, command, index, value, input ready);
   modport sink   (input valid, command, index, value, output ready);
endinterface

interface nds_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] note_value;
   logic        note_start;
   logic        cycle_wrapped;
   logic [15:0] attack_time;
   logic [15:0] decay_time;
   logic [15:0] sustain_time;
   logic [15:0] release_time;
   logic        sustain_gain;
   modport source (output valid, note_value, note_start, cycle_wrapped, attack_time,
                   decay_time, sustain_time, release_time, sustain_gain,
                   input ready);
   modport sink   (input valid, note_value, note_start, cycle_wrapped, attack_time,
                   decay_time, sustain_time, release_time, sustain_gain,
                   output ready);
endinterface

/* rtl/nds_div4.sv */
// Four restoring dividers sharing one divisor, one quotient bit per cycle.
module nds_div4 (
   input  logic                                  clock,
   input  logic                                  reset,
   input  nds_pkg::div_ctl_type                  ctl,
   input  logic [3:0][nds_pkg::DividendW-1:0]    dividend,
   input  logic [nds_pkg::SumW-1:0]              divisor,
   output nds_pkg::div_sts_type                  sts,
   output logic [3:0][nds_pkg::TimeW-1:0]        quotient
);

   logic [3:0][nds_pkg::DividendW-1:0] work_ff, work_in;
   logic [3:0][nds_pkg::SumW-1:0]      rem_ff, rem_in;
   logic [nds_pkg::SumW-1:0]           dsr_ff, dsr_in;
   logic [nds_pkg::DivCountW-1:0]      cnt_ff, cnt_in;
   logic                               busy_ff, busy_in;
   logic                               done_ff, done_in;
   logic [3:0][nds_pkg::SumW:0]        trial;

   always_comb begin
      work_in = work_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      for (int i = 0; i < 4; i++) begin
         trial[i] = {rem_ff[i], work_ff[i][nds_pkg::DividendW-1]};
      end
      if (ctl.start) begin
         work_in = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         for (int i = 0; i < 4; i++) begin
            if (trial[i] >= {1'b0, dsr_ff}) begin
               rem_in[i]  = nds_pkg::SumW'(trial[i] - {1'b0, dsr_ff});
               work_in[i] = {work_ff[i][nds_pkg::DividendW-2:0], 1'b1};
            end else begin
               rem_in[i]  = trial[i][nds_pkg::SumW-1:0];
               work_in[i] = {work_ff[i][nds_pkg::DividendW-2:0], 1'b0};
            end
         end
         cnt_in = cnt_ff + nds_pkg::DivCountW'(1);
         if (cnt_ff == nds_pkg::DivCountW'(nds_pkg::DividendW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      work_ff <= work_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
   end

   always_comb begin
      sts.busy = busy_ff;
      sts.done = done_ff;
      for (int i = 0; i < 4; i++) begin
         quotient[i] = work_ff[i][nds_pkg::TimeW-1:0];
      end
   end

endmodule

/* rtl/note_duration_step_sequencer.sv */
// Note/duration step sequencer with per-note envelope times.
// Channels: req_chan carries commands (tick, trigger, table writes, envelope
// write, restart); rsp_chan returns one result for every tick and nothing for
// the other commands. csr_we/csr_index/csr_wdata write the configuration; write
// it only while the block is idle.
// Timing: one request at a time. A table write, trigger or idle tick is taken
// from the idle state; a tick that holds its note answers the cycle after. A new
// note first reads the note memory; in manual mode the result follows at once, in
// automatic mode the envelope fit adds the length and scale states, and a rescale
// runs the four-lane divider before the result is shown.
// Restart passes through the note memory read and then returns to idle.
// Reset clears positions to count-1, countdown and current note to zero and
// restores the envelope times; the note and duration tables hold rubbish until
// written.
// A stalled receiver holds the result in the output register; no request is
// taken until it has gone.
module note_duration_step_sequencer (
   input  logic                              clock,
   input  logic                              reset,
   nds_req_if.sink                           req_chan,
   nds_rsp_if.source                         rsp_chan,
   input  logic                              csr_we,
   input  logic [nds_pkg::CsrIndexW-1:0]     csr_index,
   input  logic [nds_pkg::CsrDataW-1:0]      csr_wdata
);

   localparam int PosW  = nds_pkg::PosW;
   localparam int TimeW = nds_pkg::TimeW;
   localparam int SumW  = nds_pkg::SumW;

   // configuration
   logic [31:0]                 spu_ff, ms_ff;
   logic [nds_pkg::CountW-1:0]  ncnt_ff, dcnt_ff;
   logic                        manual_ff, elastic_ff, sus_lvl_ff;

   // state
   nds_pkg::state_type          state_ff, state_in;
   nds_pkg::op_type             op_ff;
   logic [PosW-1:0]             npos_ff, dpos_ff;
   logic [31:0]                 countdown_ff;
   logic [31:0]                 cur_note_ff;
   logic                        trig_ff;
   logic [3:0][TimeW-1:0]       env_ff;
   logic                        start_ff, wrap_ff;
   logic [47:0]                 len_prod_ff;
   logic [TimeW-1:0]            len_ff;
   logic [3:0][TimeW-1:0]       seg_ff;
   logic [SumW-1:0]             sum_ff;
   logic [3:0][TimeW-1:0]       out_seg_ff;

   // memories
   logic [31:0]                 note_mem [nds_pkg::MaxSteps];
   logic [TimeW-1:0]            dur_mem  [nds_pkg::MaxSteps];
   logic [31:0]                 note_rd_ff;
   logic [TimeW-1:0]            dur_rd_ff;
   logic [PosW-1:0]             note_raddr, dur_raddr;

   nds_pkg::cmd_type            cmd;
   logic                        req_fire, rsp_fire;
   nds_pkg::step_type           nadv, dadv;
   logic [47:0]                 reload_prod;
   logic [TimeW-1:0]            len_sat;
   logic [SumW-1:0]             others, elastic_s;
   logic [TimeW-1:0]            s_sel;
   logic [SumW-1:0]             sum_calc;
   logic [31:0]                 env_val;

   nds_pkg::div_ctl_type                   div_ctl;
   nds_pkg::div_sts_type                   div_sts;
   logic [3:0][nds_pkg::DividendW-1:0]     div_dividend;
   logic [3:0][TimeW-1:0]                  div_quot;

   assign cmd      = nds_pkg::cmd_type'(req_chan.command);
   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_fire = rsp_chan.valid && rsp_chan.ready;
   assign nadv     = nds_pkg::advance(npos_ff, ncnt_ff);
   assign dadv     = nds_pkg::advance(dpos_ff, dcnt_ff);

   always_comb begin
      note_raddr = (cmd == nds_pkg::CMD_RESTART) ? '0 : nadv.pos;
      dur_raddr  = dadv.pos;
   end

   always_ff @(posedge clock) begin
      if (req_fire && cmd == nds_pkg::CMD_WR_NOTE) begin
         note_mem[req_chan.index[PosW-1:0]] <= req_chan.value;
      end
      if (req_fire && cmd == nds_pkg::CMD_WR_DUR) begin
         dur_mem[req_chan.index[PosW-1:0]] <= req_chan.value[TimeW-1:0];
      end
      note_rd_ff <= note_mem[note_raddr];
      dur_rd_ff  <= dur_mem[dur_raddr];
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         spu_ff     <= '0;
         ms_ff      <= nds_pkg::MsPerUnitReset;
         ncnt_ff    <= nds_pkg::CountReset;
         dcnt_ff    <= nds_pkg::CountReset;
         manual_ff  <= 1'b0;
         elastic_ff <= 1'b0;
         sus_lvl_ff <= 1'b1;
      end else if (csr_we) begin
         unique case (nds_pkg::csr_index_type'(csr_index))
            nds_pkg::CSR_SAMPLES_PER_UNIT: spu_ff     <= csr_wdata;
            nds_pkg::CSR_MS_PER_UNIT:      ms_ff      <= csr_wdata;
            nds_pkg::CSR_NOTE_COUNT:       ncnt_ff    <= csr_wdata[nds_pkg::CountW-1:0];
            nds_pkg::CSR_DURATION_COUNT:   dcnt_ff    <= csr_wdata[nds_pkg::CountW-1:0];
            nds_pkg::CSR_MANUAL_MODE:      manual_ff  <= csr_wdata[0];
            nds_pkg::CSR_ELASTIC_SUSTAIN:  elastic_ff <= csr_wdata[0];
            nds_pkg::CSR_SUSTAIN_LEVEL:    sus_lvl_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // datapath arithmetic
   always_comb begin
      reload_prod = 48'(dur_rd_ff) * 48'(spu_ff);
      if (|len_prod_ff[47:40]) len_sat = '1;
      else                     len_sat = len_prod_ff[39:24];
      others    = SumW'(env_ff[0]) + SumW'(env_ff[1]) + SumW'(env_ff[3]);
      elastic_s = ({2'b00, len_sat} > others) ? SumW'({2'b00, len_sat} - others) : '0;
      if (!elastic_ff)                  s_sel = env_ff[2];
      else if (elastic_s < SumW'(1))    s_sel = TimeW'(1);
      else                              s_sel = elastic_s[TimeW-1:0];
      sum_calc = others + SumW'(s_sel);
      for (int i = 0; i < 4; i++) begin
         div_dividend[i] = nds_pkg::DividendW'(seg_ff[i]) * nds_pkg::DividendW'(len_ff);
      end
      if (req_chan.value == '0)                   env_val = 32'd1;
      else if (req_chan.value > 32'(16'hFFFF))    env_val = 32'(16'hFFFF);
      else                                        env_val = req_chan.value;
   end

   assign div_ctl.start = (state_ff == nds_pkg::ST_SCALE) && ({2'b00, len_ff} < sum_ff);

   nds_div4 u_div (
      .clock    (clock),
      .reset    (reset),
      .ctl      (div_ctl),
      .dividend (div_dividend),
      .divisor  (sum_ff),
      .sts      (div_sts),
      .quotient (div_quot)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         nds_pkg::ST_IDLE: begin
            if (req_fire) begin
               priority case (cmd)
                  nds_pkg::CMD_TICK: begin
                     if (manual_ff) state_in = trig_ff ? nds_pkg::ST_READ : nds_pkg::ST_OUT;
                     else state_in = (countdown_ff == '0) ? nds_pkg::ST_READ
                                                          : nds_pkg::ST_OUT;
                  end
                  nds_pkg::CMD_RESTART: state_in = nds_pkg::ST_READ;
                  default:              state_in = nds_pkg::ST_IDLE;
               endcase
            end
         end
         nds_pkg::ST_READ: begin
            unique case (op_ff)
               nds_pkg::OP_RESTART: state_in = nds_pkg::ST_IDLE;
               nds_pkg::OP_MANUAL:  state_in = nds_pkg::ST_OUT;
               default:             state_in = nds_pkg::ST_LEN;
            endcase
         end
         nds_pkg::ST_LEN:   state_in = nds_pkg::ST_SCALE;
         nds_pkg::ST_SCALE: state_in = div_ctl.start ? nds_pkg::ST_DIV : nds_pkg::ST_OUT;
         nds_pkg::ST_DIV:   if (div_sts.done) state_in = nds_pkg::ST_OUT;
         nds_pkg::ST_OUT:   if (rsp_fire) state_in = nds_pkg::ST_IDLE;
         default:           state_in = nds_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_chan.ready             = (state_ff == nds_pkg::ST_IDLE);
      rsp_chan.valid             = (state_ff == nds_pkg::ST_OUT);
      rsp_chan.note_value        = cur_note_ff;
      rsp_chan.note_start        = start_ff;
      rsp_chan.cycle_wrapped     = wrap_ff;
      rsp_chan.attack_time       = start_ff ? out_seg_ff[0] : '0;
      rsp_chan.decay_time        = start_ff ? out_seg_ff[1] : '0;
      rsp_chan.sustain_time      = start_ff ? out_seg_ff[2] : '0;
      rsp_chan.release_time      = start_ff ? out_seg_ff[3] : '0;
      rsp_chan.sustain_gain      = sus_lvl_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= nds_pkg::ST_IDLE;
         op_ff        <= nds_pkg::OP_AUTO;
         npos_ff      <= nds_pkg::last_pos(nds_pkg::CountReset);
         dpos_ff      <= nds_pkg::last_pos(nds_pkg::CountReset);
         countdown_ff <= '0;
         cur_note_ff  <= '0;
         trig_ff      <= 1'b0;
         env_ff       <= {nds_pkg::EnvResetR, nds_pkg::EnvResetS,
                          nds_pkg::EnvResetD, nds_pkg::EnvResetA};
         start_ff     <= 1'b0;
         wrap_ff      <= 1'b0;
      end else begin
         state_ff <= state_in;
         unique case (state_ff)
            nds_pkg::ST_IDLE: begin
               if (req_fire) begin
                  priority case (cmd)
                     nds_pkg::CMD_TICK: begin
                        start_ff <= 1'b0;
                        wrap_ff  <= 1'b0;
                        if (manual_ff) begin
                           if (trig_ff) begin
                              trig_ff  <= 1'b0;
                              npos_ff  <= nadv.pos;
                              wrap_ff  <= nadv.wrap;
                              start_ff <= 1'b1;
                              op_ff    <= nds_pkg::OP_MANUAL;
                           end
                        end else if (countdown_ff == '0) begin
                           npos_ff  <= nadv.pos;
                           dpos_ff  <= dadv.pos;
                           wrap_ff  <= nadv.wrap;
                           start_ff <= 1'b1;
                           op_ff    <= nds_pkg::OP_AUTO;
                        end else begin
                           countdown_ff <= countdown_ff - 32'd1;
                        end
                     end
                     nds_pkg::CMD_TRIGGER: trig_ff <= 1'b1;
                     nds_pkg::CMD_WR_ENV: begin
                        if (req_chan.index < 6'd4) begin
                           env_ff[req_chan.index[1:0]] <= env_val[TimeW-1:0];
                        end
                     end
                     nds_pkg::CMD_RESTART: begin
                        countdown_ff <= '0;
                        npos_ff      <= nds_pkg::last_pos(ncnt_ff);
                        dpos_ff      <= nds_pkg::last_pos(dcnt_ff);
                        op_ff        <= nds_pkg::OP_RESTART;
                     end
                     default: ;
                  endcase
               end
            end
            nds_pkg::ST_READ: begin
               cur_note_ff <= note_rd_ff;
               if (op_ff == nds_pkg::OP_AUTO) begin
                  countdown_ff <= 32'(reload_prod[47:24]);
               end
            end
            default: ;
         endcase
      end
   end

   // payload registers of the envelope fit
   always_ff @(posedge clock) begin
      unique case (state_ff)
         nds_pkg::ST_READ: begin
            len_prod_ff <= 48'(dur_rd_ff) * 48'(ms_ff);
            out_seg_ff  <= env_ff;
         end
         nds_pkg::ST_LEN: begin
            len_ff <= len_sat;
            seg_ff <= {env_ff[3], s_sel, env_ff[1], env_ff[0]};
            sum_ff <= sum_calc;
         end
         nds_pkg::ST_SCALE: begin
            if (!div_ctl.start) out_seg_ff <= seg_ff;
         end
         nds_pkg::ST_DIV: begin
            if (div_sts.done) out_seg_ff <= div_quot;
         end
         default: ;
      endcase
   end

endmodule

/* rtl/nds_checker.sv */
module nds_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        note_start,
   input logic        cycle_wrapped,
   input logic [15:0] attack_time,
   input logic [15:0] sustain_time
);

   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid) else $error("result shown straight after reset");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("result dropped while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("request taken while result waits");

   a_wrap_needs_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && cycle_wrapped |-> note_start) else $error("wrap without new note");

   a_env_zero_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !note_start |-> attack_time == 16'd0 && sustain_time == 16'd0)
      else $error("envelope times on held note");

endmodule

bind note_duration_step_sequencer nds_checker u_nds_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .note_start    (rsp_chan.note_start),
   .cycle_wrapped (rsp_chan.cycle_wrapped),
   .attack_time   (rsp_chan.attack_time),
   .sustain_time  (rsp_chan.sustain_time)
);

/* sim/note_duration_step_sequencer_tb.sv */
module note_duration_step_sequencer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [31:0] note;
      logic        start;
      logic        wrap;
      logic [15:0] attack;
      logic [15:0] decay;
      logic [15:0] sustain;
      logic [15:0] release_ms;
      logic        amplitude;
   } tick_result_type;

   class sequencer_scoreboard;
      bit [31:0]   spu, mpu;
      bit [6:0]    ncount, dcount;
      bit          manual, elastic, level;
      bit [31:0]   notes [nds_pkg::MaxSteps];
      bit [15:0]   durs [nds_pkg::MaxSteps];
      bit [15:0]   env [4];
      int unsigned npos, dpos;
      bit [31:0]   countdown, cur_note;
      bit          trig;
      tick_result_type pending_ticks[$];
      int          errors;

      function int unsigned clampc(bit [6:0] c);
         if (c < 2) return 2;
         if (c > nds_pkg::MaxSteps) return nds_pkg::MaxSteps;
         return c;
      endfunction

      function void reset_state();
         spu = 0; mpu = nds_pkg::MsPerUnitReset;
         ncount = nds_pkg::CountReset; dcount = nds_pkg::CountReset;
         manual = 0; elastic = 0; level = 1;
         env[0] = nds_pkg::EnvResetA; env[1] = nds_pkg::EnvResetD;
         env[2] = nds_pkg::EnvResetS; env[3] = nds_pkg::EnvResetR;
         npos = clampc(ncount) - 1; dpos = clampc(dcount) - 1;
         countdown = 0; cur_note = 0; trig = 0;
         errors = 0;
      endfunction

      function void set_reg(nds_pkg::csr_index_type i, bit [31:0] v);
         case (i)
            nds_pkg::CSR_SAMPLES_PER_UNIT: spu = v;
            nds_pkg::CSR_MS_PER_UNIT:      mpu = v;
            nds_pkg::CSR_NOTE_COUNT:       ncount = v[6:0];
            nds_pkg::CSR_DURATION_COUNT:   dcount = v[6:0];
            nds_pkg::CSR_MANUAL_MODE:      manual = v[0];
            nds_pkg::CSR_ELASTIC_SUSTAIN:  elastic = v[0];
            nds_pkg::CSR_SUSTAIN_LEVEL:    level = v[0];
            default: ;
         endcase
      endfunction

      function int unsigned step_pos(int unsigned p, bit [6:0] c, output bit wrapped);
         int unsigned n;
         n = p + 1;
         wrapped = (n >= clampc(c));
         return wrapped ? 0 : n;
      endfunction

      function void fit_envelope(ref tick_result_type res);
         longint unsigned a, d, s, r, len, sum, others;
         a = env[0]; d = env[1]; s = env[2]; r = env[3];
         if (!manual) begin
            len = (longint'(durs[dpos % nds_pkg::MaxSteps]) * mpu) >> 24;
            if (len > 65535) len = 65535;
            if (elastic) begin
               others = a + d + r;
               s = (len > others) ? len - others : 0;
               if (s < 1) s = 1;
            end
            sum = a + d + s + r;
            if (sum > len) begin
               a = a * len / sum; d = d * len / sum;
               s = s * len / sum; r = r * len / sum;
            end
         end
         res.attack = a[15:0]; res.decay = d[15:0];
         res.sustain = s[15:0]; res.release_ms = r[15:0];
      endfunction

      function void accept(nds_pkg::cmd_type c, bit [5:0] idx, bit [31:0] v);
         tick_result_type res;
         bit dwrap;
         res = '0;
         case (c)
            nds_pkg::CMD_TICK: begin
               if (manual) begin
                  if (trig) begin
                     trig = 0;
                     npos = step_pos(npos, ncount, res.wrap);
                     cur_note = notes[npos % nds_pkg::MaxSteps];
                     res.start = 1;
                  end
               end else if (countdown == 0) begin
                  npos = step_pos(npos, ncount, res.wrap);
                  dpos = step_pos(dpos, dcount, dwrap);
                  countdown = 32'((longint'(durs[dpos % nds_pkg::MaxSteps]) * spu) >> 24);
                  cur_note = notes[npos % nds_pkg::MaxSteps];
                  res.start = 1;
               end else begin
                  countdown--;
               end
               res.note = cur_note;
               if (res.start) fit_envelope(res);
               res.amplitude = level;
               pending_ticks.push_back(res);
            end
            nds_pkg::CMD_TRIGGER: trig = 1;
            nds_pkg::CMD_WR_NOTE: notes[idx] = v;
            nds_pkg::CMD_WR_DUR:  durs[idx] = v[15:0];
            nds_pkg::CMD_WR_ENV: begin
               if (idx < 4) env[idx] = (v == 0) ? 16'd1 : (v > 65535) ? 16'hFFFF : v[15:0];
            end
            nds_pkg::CMD_RESTART: begin
               countdown = 0;
               cur_note = notes[0];
               npos = clampc(ncount) - 1;
               dpos = clampc(dcount) - 1;
            end
            default: ;
         endcase
      endfunction

      function void cmp(string f, longint unsigned e, longint unsigned g);
         if (e != g) begin
            errors++;
            $display("%0t mismatch %s expected %0h actual %0h", $time, f, e, g);
         end
      endfunction

      function void check(tick_result_type got);
         tick_result_type e;
         if (pending_ticks.size() == 0) begin
            errors++;
            $display("%0t unexpected result, expected none, actual %h", $time, got);
            return;
         end
         e = pending_ticks.pop_front();
         cmp("note_value", e.note, got.note);
         cmp("note_start", e.start, got.start);
         cmp("cycle_wrapped", e.wrap, got.wrap);
         cmp("attack_time", e.attack, got.attack);
         cmp("decay_time", e.decay, got.decay);
         cmp("sustain_time", e.sustain, got.sustain);
         cmp("release_time", e.release_ms, got.release_ms);
         cmp("sustain_gain", e.amplitude, got.amplitude);
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic csr_we = 0;
   logic [nds_pkg::CsrIndexW-1:0] csr_index = '0;
   logic [nds_pkg::CsrDataW-1:0]  csr_wdata = '0;

   nds_req_if req();
   nds_rsp_if rsp();

   note_duration_step_sequencer dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req),
      .rsp_chan  (rsp),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   sequencer_scoreboard sb = new();
   bit steady = 0;
   bit hold_go = 0;
   int hold_left = 0;
   int idle_cycles = 0;
   int unsigned dur_cap = 16'hFFFF;

   always #5 clock = ~clock;

   // receiver side: random stalls plus one long hold-off on request
   always @(negedge clock) begin
      if (hold_go) begin
         hold_left = 400;
         hold_go = 0;
      end
      if (hold_left > 0) begin
         rsp.ready = 0;
         hold_left--;
      end else begin
         rsp.ready = steady || ($urandom_range(99) >= 13);
      end
   end

   always @(posedge clock) begin
      if (!reset && req.valid && req.ready)
         sb.accept(nds_pkg::cmd_type'(req.command), req.index, req.value);
      if (!reset && rsp.valid && rsp.ready)
         sb.check({rsp.note_value, rsp.note_start, rsp.cycle_wrapped, rsp.attack_time,
                   rsp.decay_time, rsp.sustain_time, rsp.release_time,
                   rsp.sustain_gain});
   end

   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= 3000) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic send_req(nds_pkg::cmd_type c, logic [5:0] i, logic [31:0] v);
      @(negedge clock);
      if (!steady && $urandom_range(99) < 13) begin
         req.valid = 0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req.valid = 1; req.command = c; req.index = i; req.value = v;
      do @(posedge clock); while (!req.ready);
   endtask

   // drop valid and let the block drain, including any request with no result
   task automatic drain();
      @(negedge clock);
      req.valid = 0;
      while (sb.pending_ticks.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_reg(nds_pkg::csr_index_type i, logic [31:0] v);
      @(negedge clock);
      csr_we = 1; csr_index = i; csr_wdata = v;
      sb.set_reg(i, v);
   endtask

   task automatic set_phase(logic [31:0] spu, logic [31:0] mpu, logic [6:0] nc,
                            logic [6:0] dc, bit man, bit ela, bit lvl, int unsigned cap);
      drain();
      write_reg(nds_pkg::CSR_SAMPLES_PER_UNIT, spu);
      write_reg(nds_pkg::CSR_MS_PER_UNIT, mpu);
      write_reg(nds_pkg::CSR_NOTE_COUNT, {$urandom} & 32'hFFFF_FF80 | nc);
      write_reg(nds_pkg::CSR_DURATION_COUNT, {$urandom} & 32'hFFFF_FF80 | dc);
      write_reg(nds_pkg::CSR_MANUAL_MODE, {$urandom} & 32'hFFFF_FFFE | man);
      write_reg(nds_pkg::CSR_ELASTIC_SUSTAIN, {$urandom} & 32'hFFFF_FFFE | ela);
      write_reg(nds_pkg::CSR_SUSTAIN_LEVEL, {$urandom} & 32'hFFFF_FFFE | lvl);
      @(negedge clock);
      csr_we = 0;
      dur_cap = cap;
      // durations are bounded so the countdown stays short at this rate
      for (int k = 0; k < nds_pkg::MaxSteps; k++)
         send_req(nds_pkg::CMD_WR_DUR, 6'(k), {16'($urandom), 16'($urandom_range(0, cap))});
   endtask

   task automatic random_requests(int count);
      int unsigned p;
      for (int k = 0; k < count; k++) begin
         p = $urandom_range(99);
         if (p < 55) send_req(nds_pkg::CMD_TICK, 6'($urandom), $urandom);
         else if (p < 65) send_req(nds_pkg::CMD_TRIGGER, 6'($urandom), $urandom);
         else if (p < 74) send_req(nds_pkg::CMD_WR_NOTE, 6'($urandom), $urandom);
         else if (p < 82)
            send_req(nds_pkg::CMD_WR_DUR, 6'($urandom),
                     {16'($urandom), 16'($urandom_range(0, dur_cap))});
         else if (p < 92)
            send_req(nds_pkg::CMD_WR_ENV, 6'($urandom_range(0, 5)),
                     ($urandom_range(9) < 7) ? $urandom_range(0, 300) : $urandom);
         else if (p < 97) send_req(nds_pkg::CMD_RESTART, 6'($urandom), $urandom);
         else send_req($urandom_range(1) ? nds_pkg::CMD_RSVD6 : nds_pkg::CMD_RSVD7,
                       6'($urandom), $urandom);
      end
   endtask

   initial begin
      req.valid = 0; req.command = '0; req.index = '0; req.value = '0;
      sb.reset_state();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // every table entry written before anything can read it
      for (int k = 0; k < nds_pkg::MaxSteps; k++)
         send_req(nds_pkg::CMD_WR_NOTE, 6'(k), $urandom);
      for (int k = 0; k < nds_pkg::MaxSteps; k++)
         send_req(nds_pkg::CMD_WR_DUR, 6'(k), {16'($urandom), 16'($urandom)});

      // directed: reset config, zero countdown reload
      repeat (3) send_req(nds_pkg::CMD_TICK, '0, '0);
      send_req(nds_pkg::CMD_WR_ENV, 6'd0, 32'd0);
      send_req(nds_pkg::CMD_WR_ENV, 6'd1, 32'hFFFF_FFFF);
      send_req(nds_pkg::CMD_WR_ENV, 6'd2, 32'd70000);
      send_req(nds_pkg::CMD_WR_ENV, 6'd3, 32'd1);
      send_req(nds_pkg::CMD_WR_ENV, 6'd4, 32'd5);
      send_req(nds_pkg::CMD_WR_ENV, 6'd63, 32'd7);
      send_req(nds_pkg::CMD_TICK, 6'd63, 32'hFFFF_FFFF);
      send_req(nds_pkg::CMD_RSVD6, 6'd1, 32'd1);
      send_req(nds_pkg::CMD_RSVD7, 6'd2, 32'd2);
      send_req(nds_pkg::CMD_TRIGGER, '0, '0);
      send_req(nds_pkg::CMD_TICK, '0, '0);
      send_req(nds_pkg::CMD_RESTART, '0, '0);
      send_req(nds_pkg::CMD_TICK, '0, '0);
      send_req(nds_pkg::CMD_WR_NOTE, 6'd63, 32'hFFFF_FFFF);
      send_req(nds_pkg::CMD_WR_DUR, 6'd63, 32'h0000_FFFF);
      send_req(nds_pkg::CMD_WR_NOTE, 6'd0, 32'd0);
      send_req(nds_pkg::CMD_WR_ENV, 6'd0, 32'd10);
      send_req(nds_pkg::CMD_WR_ENV, 6'd1, 32'd20);
      send_req(nds_pkg::CMD_WR_ENV, 6'd2, 32'd100);
      send_req(nds_pkg::CMD_WR_ENV, 6'd3, 32'd30);
      repeat (2) send_req(nds_pkg::CMD_TICK, '0, '0);
      random_requests(100);

      set_phase(32'h0010_0000, 32'hFFFF_FFFF, 7'd64, 7'd64, 0, 0, 0, 16'h7F);
      random_requests(115);

      set_phase(32'hFFFF_FFFF, nds_pkg::MsPerUnitReset, 7'd2, 7'd2, 0, 1, 1, 8);
      steady = 1;
      random_requests(115);
      steady = 0;

      set_phase(32'h0001_0000, 32'd0, 7'd1, 7'd127, 0, 1, 0, 16'h3FF);
      hold_go = 1;
      random_requests(115);

      set_phase(32'h0010_0000, 32'h0123_4567, 7'd7, 7'd5, 1, 0, 1, 16'h7F);
      random_requests(115);

      set_phase(32'd0, 32'h00A0_0000, 7'd100, 7'd3, 0, 1, 1, 16'hFFFF);
      random_requests(115);

      drain();
      if (sb.errors == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end
endmodule
